@@ hdl/imrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imrt_pkg
// types and constants shared by the breakpoint table front end and engine
// ----------------------------------------------------------------------------
package imrt_pkg;

	localparam int MAX_BP     = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 8;
	localparam int IDX_BITS   = $clog2(MAX_BP);
	localparam int CNT_BITS   = $clog2(MAX_BP + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

	typedef enum logic [0:0] {
		OP_LOOKUP = 1'b0,
		OP_ASSIGN = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                         operation;
		logic signed [KEY_BITS-1:0]   lookup_key;
		logic signed [KEY_BITS-1:0]   range_begin;
		logic signed [KEY_BITS-1:0]   range_end;
		logic        [VALUE_BITS-1:0] new_value;
	} req_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] found_value;
		logic [1:0]            status;
		logic [4:0]            entries_used;
	} rsp_t;

	// classified request handed from the front end to the engine
	typedef struct packed {
		logic                  is_assign;
		logic                  empty_range;
		logic [KEY_BITS-1:0]   key_a;   // biased lookup key or range begin
		logic [KEY_BITS-1:0]   key_b;   // biased range end
		logic [VALUE_BITS-1:0] value;
	} cmd_t;

	typedef enum logic [2:0] {
		EN_IDLE,
		EN_SCAN,
		EN_BUILD,
		EN_COPY,
		EN_REPLY
	} eng_state_t;

endpackage

@@ hdl/interval_map_range_table_core.sv @@
`timescale 1ns / 1ps
// a lookup or an empty assign runs scan then reply; a non-empty assign runs scan, build, copy, reply
// the engine runs one request at a time, through the scan / build / copy / reply sequence;
// reply waits while the last result is unpopped
// a two-entry request queue lets pushes land while the engine works
// reset: arst_n clears the table count, queue and default value to empty / zero
// ----------------------------------------------------------------------------
// interval_map_range_table_core
// sorted breakpoint table with lookup and canonical range assign
// ----------------------------------------------------------------------------
module interval_map_range_table_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  imrt_pkg::req_t                  req,
	input  logic                            push,
	output logic                            full,
	output imrt_pkg::rsp_t                  rsp,
	output logic                            empty,
	input  logic                            pop,
	input  logic [imrt_pkg::VALUE_BITS-1:0] cfg_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready
);
	import imrt_pkg::*;

	cmd_t                  cmd;
	logic                  cmd_valid, cmd_take, eng_idle;
	logic [VALUE_BITS-1:0] default_q;

	// default changes only with nothing in flight
	assign cfg_ready = eng_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) default_q <= '0;
		else if (cfg_valid && cfg_ready) default_q <= cfg_data;
	end

	imrt_front u_front (
		.clk, .arst_n, .req, .push, .full,
		.cmd, .cmd_valid, .cmd_take
	);

	imrt_engine u_engine (
		.clk, .arst_n, .default_value(default_q),
		.cmd, .cmd_valid, .cmd_take,
		.rsp, .empty, .pop, .idle(eng_idle)
	);

endmodule

@@ hdl/imrt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imrt_front
// accepts requests, biases keys and flags empty ranges into a short queue
// ----------------------------------------------------------------------------
module imrt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  imrt_pkg::req_t req,
	input  logic           push,
	output logic           full,
	output imrt_pkg::cmd_t cmd,
	output logic           cmd_valid,
	input  logic           cmd_take
);
	import imrt_pkg::*;

	cmd_t                 queue_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   fill_q;
	cmd_t                 in_cmd;
	logic                 do_push, do_pop;

	always_comb begin
		in_cmd.is_assign   = (req.operation == OP_ASSIGN);
		in_cmd.key_a       = (req.operation == OP_ASSIGN) ?
			{~req.range_begin[KEY_BITS-1], req.range_begin[KEY_BITS-2:0]} :
			{~req.lookup_key[KEY_BITS-1], req.lookup_key[KEY_BITS-2:0]};
		in_cmd.key_b       = {~req.range_end[KEY_BITS-1], req.range_end[KEY_BITS-2:0]};
		in_cmd.empty_range = !(req.range_begin < req.range_end);
		in_cmd.value       = req.new_value;
	end

	assign full      = (fill_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_take;

	always_ff @(posedge clk) begin
		if (do_push) queue_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			fill_q <= fill_q + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
		end
	end

endmodule

@@ hdl/imrt_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imrt_engine
// runs lookups and range assigns against the breakpoint table
// ----------------------------------------------------------------------------
module imrt_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [imrt_pkg::VALUE_BITS-1:0] default_value,
	input  imrt_pkg::cmd_t                  cmd,
	input  logic                            cmd_valid,
	output logic                            cmd_take,
	output imrt_pkg::rsp_t                  rsp,
	output logic                            empty,
	input  logic                            pop,
	output logic                            idle
);
	import imrt_pkg::*;

	logic [KEY_BITS-1:0]   keys_q [MAX_BP];
	logic [VALUE_BITS-1:0] vals_q [MAX_BP];
	logic [KEY_BITS-1:0]   nkeys_q [MAX_BP];
	logic [VALUE_BITS-1:0] nvals_q [MAX_BP];
	logic [CNT_BITS-1:0]   count_q, ncount_q;
	logic [MAX_BP-1:0]     lt_b_q, le_b_q, gt_e_q, le_e_q;
	cmd_t                  cmd_q;
	eng_state_t            state_q, state_d;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic                  overflow_q;

	// scan results, combinational over registered compare masks
	logic [VALUE_BITS-1:0] before_v, at_b_v, at_e_v;
	logic [CNT_BITS-1:0]   n_lt, n_gt;
	logic [CNT_BITS+1:0]   n_total;
	logic                  add_b, add_e;

	always_comb begin
		before_v = default_value;
		at_b_v   = default_value;
		at_e_v   = default_value;
		n_lt     = '0;
		n_gt     = '0;
		for (int i = 0; i < MAX_BP; i++) begin
			if (lt_b_q[i]) before_v = vals_q[i];
			if (le_b_q[i]) at_b_v   = vals_q[i];
			if (le_e_q[i]) at_e_v   = vals_q[i];
			n_lt = n_lt + CNT_BITS'(lt_b_q[i]);
			n_gt = n_gt + CNT_BITS'(gt_e_q[i]);
		end
		add_b   = (cmd_q.value != before_v);
		add_e   = (at_e_v != cmd_q.value);
		n_total = (CNT_BITS+2)'(n_lt) + (CNT_BITS+2)'(n_gt)
			+ (CNT_BITS+2)'(add_b) + (CNT_BITS+2)'(add_e);
	end

	assign cmd_take = (state_q == EN_IDLE) && cmd_valid;
	assign empty    = !rsp_valid_q;
	assign rsp      = rsp_q;
	assign idle     = (state_q == EN_IDLE) && !cmd_valid && !rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			EN_IDLE:  if (cmd_valid) state_d = EN_SCAN;
			EN_SCAN:  state_d = (cmd_q.is_assign && !cmd_q.empty_range) ? EN_BUILD : EN_REPLY;
			EN_BUILD: state_d = EN_COPY;
			EN_COPY:  state_d = EN_REPLY;
			EN_REPLY: if (!rsp_valid_q) state_d = EN_IDLE;
			default:  state_d = EN_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EN_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && pop) rsp_valid_q <= 1'b0;
			if (state_q == EN_COPY && !overflow_q) count_q <= ncount_q;
			if (state_q == EN_REPLY && !rsp_valid_q) rsp_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			EN_IDLE: begin
				cmd_q <= cmd;
			end
			EN_SCAN: begin
				for (int i = 0; i < MAX_BP; i++) begin
					lt_b_q[i] <= (CNT_BITS'(i) < count_q) && (keys_q[i] <  cmd_q.key_a);
					le_b_q[i] <= (CNT_BITS'(i) < count_q) && (keys_q[i] <= cmd_q.key_a);
					gt_e_q[i] <= (CNT_BITS'(i) < count_q) && (keys_q[i] >  cmd_q.key_b);
					le_e_q[i] <= (CNT_BITS'(i) < count_q) && (keys_q[i] <= cmd_q.key_b);
				end
			end
			EN_BUILD: begin
				// kept entries below begin sit in place; new ones follow, then the tail
				overflow_q <= (n_total > (CNT_BITS+2)'(MAX_BP));
				ncount_q   <= CNT_BITS'(n_total);
				for (int i = 0; i < MAX_BP; i++) begin
					nkeys_q[i] <= keys_q[i];
					nvals_q[i] <= vals_q[i];
				end
				for (int j = 0; j < MAX_BP; j++) begin
					if (CNT_BITS'(j) == n_lt && add_b) begin
						nkeys_q[j] <= cmd_q.key_a;
						nvals_q[j] <= cmd_q.value;
					end else if (CNT_BITS'(j) == n_lt + CNT_BITS'(add_b) && add_e) begin
						nkeys_q[j] <= cmd_q.key_b;
						nvals_q[j] <= at_e_v;
					end
				end
				// tail entries: source i moves to i - (count - n_gt) + n_lt + adds
				for (int i = 0; i < MAX_BP; i++) begin
					if (gt_e_q[i]) begin
						nkeys_q[IDX_BITS'(CNT_BITS'(i) - (count_q - n_gt) + n_lt
							+ CNT_BITS'(add_b) + CNT_BITS'(add_e))] <= keys_q[i];
						nvals_q[IDX_BITS'(CNT_BITS'(i) - (count_q - n_gt) + n_lt
							+ CNT_BITS'(add_b) + CNT_BITS'(add_e))] <= vals_q[i];
					end
				end
			end
			EN_COPY: begin
				if (!overflow_q) begin
					for (int i = 0; i < MAX_BP; i++) begin
						keys_q[i] <= nkeys_q[i];
						vals_q[i] <= nvals_q[i];
					end
				end
			end
			EN_REPLY: begin
				if (!rsp_valid_q) begin
					rsp_q.entries_used <= 5'(count_q);
					if (!cmd_q.is_assign) begin
						rsp_q.found_value <= at_b_v;
						rsp_q.status      <= ST_DONE;
					end else begin
						rsp_q.found_value <= '0;
						rsp_q.status      <= cmd_q.empty_range ? ST_EMPTY :
							(overflow_q ? ST_FULL : ST_DONE);
					end
				end
			end
			default: ;
		endcase
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the breakpoint table core: lookups and range assigns against an
// in-bench model of the sorted table, with random gaps on both sides
// ----------------------------------------------------------------------------
module tb;
	import imrt_pkg::*;

	localparam int WATCHDOG = 20000;

	class table_scoreboard;
		logic [KEY_BITS-1:0]   bp_key [$];   // biased keys, sorted
		logic [VALUE_BITS-1:0] bp_val [$];
		logic [VALUE_BITS-1:0] dflt;
		rsp_t                  pending [$];
		int                    errors;

		function new();
			dflt = '0;
			errors = 0;
		endfunction

		function logic [VALUE_BITS-1:0] value_at(logic [KEY_BITS-1:0] k);
			logic [VALUE_BITS-1:0] v;
			v = dflt;
			foreach (bp_key[i])
				if (bp_key[i] <= k)
					v = bp_val[i];
			return v;
		endfunction

		function void note_request(req_t r);
			rsp_t                  e;
			logic [KEY_BITS-1:0]   b, en;
			logic [VALUE_BITS-1:0] prior, at_end;
			logic [KEY_BITS-1:0]   nk [$];
			logic [VALUE_BITS-1:0] nv [$];
			e = '0;
			if (op_t'(r.operation) == OP_LOOKUP) begin
				e.found_value = value_at({~r.lookup_key[KEY_BITS-1], r.lookup_key[KEY_BITS-2:0]});
			end else begin
				b  = {~r.range_begin[KEY_BITS-1], r.range_begin[KEY_BITS-2:0]};
				en = {~r.range_end[KEY_BITS-1], r.range_end[KEY_BITS-2:0]};
				if (!(b < en)) begin
					e.status = ST_EMPTY;
				end else begin
					prior = dflt;
					foreach (bp_key[i])
						if (bp_key[i] < b)
							prior = bp_val[i];
					at_end = value_at(en);
					foreach (bp_key[i])
						if (bp_key[i] < b) begin
							nk.push_back(bp_key[i]);
							nv.push_back(bp_val[i]);
						end
					if (r.new_value != prior) begin
						nk.push_back(b);
						nv.push_back(r.new_value);
					end
					if (at_end != r.new_value) begin
						nk.push_back(en);
						nv.push_back(at_end);
					end
					foreach (bp_key[i])
						if (bp_key[i] > en) begin
							nk.push_back(bp_key[i]);
							nv.push_back(bp_val[i]);
						end
					if (nk.size() > MAX_BP) begin
						e.status = ST_FULL;
					end else begin
						e.status = ST_DONE;
						bp_key = nk;
						bp_val = nv;
					end
				end
			end
			e.entries_used = 5'(bp_key.size());
			pending.push_back(e);
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.found_value !== e.found_value) begin
				$display("%0t: found_value exp %0d got %0d", $time, e.found_value, a.found_value);
				errors++;
			end
			if (a.status !== e.status) begin
				$display("%0t: status exp %0d got %0d", $time, e.status, a.status);
				errors++;
			end
			if (a.entries_used !== e.entries_used) begin
				$display("%0t: entries_used exp %0d got %0d", $time, e.entries_used,
					a.entries_used);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	req_t req = '0;
	logic push = 0;
	logic full;
	rsp_t rsp;
	logic empty;
	logic pop = 0;
	logic [VALUE_BITS-1:0] cfg_data = '0;
	logic cfg_valid = 0;
	logic cfg_ready;

	table_scoreboard sb = new();
	int  idle_cycles = 0;
	bit  hold_off = 0;
	bit  stim_done = 0;
	int  pool [16];

	always #6 clk = ~clk;

	interval_map_range_table_core dut (
		.clk(clk), .arst_n(arst_n), .req(req), .push(push), .full(full), .rsp(rsp),
		.empty(empty), .pop(pop), .cfg_data(cfg_data), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready)
	);

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// accepted-request watchdog
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(rsp);
			if (hold_off) begin
				pop <= 0;
			end else if (!pop || !empty) begin
				g = gap_len();
				if (g > 0 && $urandom_range(0, 3) == 0) begin
					pop <= 0;
					repeat (g) @(posedge clk);
					pop <= 1;
				end else begin
					pop <= 1;
				end
			end
		end
	end

	// push stays high after a request so the next one can follow without a gap
	task automatic send(req_t r);
		int g;
		g = gap_len();
		if (g > 0 && $urandom_range(0, 2) == 0) begin
			push <= 0;
			repeat (g) @(posedge clk);
		end
		req <= r;
		push <= 1;
		do @(posedge clk); while (full);
		sb.note_request(r);
	endtask

	task automatic write_default(logic [VALUE_BITS-1:0] v);
		push <= 0;
		wait (sb.pending.size() == 0);
		repeat (10) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.dflt = v;
	endtask

	function automatic req_t make_lookup(logic signed [KEY_BITS-1:0] k);
		req_t r;
		r = '0;
		r.operation = OP_LOOKUP;
		r.lookup_key = k;
		r.range_begin = $urandom;
		r.range_end = $urandom;
		r.new_value = $urandom;
		return r;
	endfunction

	function automatic req_t make_assign(logic signed [KEY_BITS-1:0] b,
		logic signed [KEY_BITS-1:0] e, logic [VALUE_BITS-1:0] v);
		req_t r;
		r.operation = OP_ASSIGN;
		r.lookup_key = $urandom;
		r.range_begin = b;
		r.range_end = e;
		r.new_value = v;
		return r;
	endfunction

	function automatic logic signed [KEY_BITS-1:0] pick_key();
		int p;
		p = $urandom_range(0, 9);
		if (p < 7) return pool[$urandom_range(0, 15)];
		if (p < 8) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		return $urandom;
	endfunction

	initial begin
		req_t r;
		logic signed [KEY_BITS-1:0] a, b;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, empty ranges, overflow
		send(make_lookup(32'sh80000000));
		send(make_assign(32'sh80000000, 32'sh7fffffff, 8'hff));
		send(make_lookup(32'sh80000000));
		send(make_lookup(32'sh7fffffff));
		send(make_assign(5, 5, 8'h11));
		send(make_assign(10, -10, 8'h11));
		send(make_assign(-100, 100, 8'h00));
		send(make_lookup(0));
		send(make_assign(-50, 50, 8'hff));
		send(make_assign(32'sh80000000, 32'sh7fffffff, 8'h00));
		for (int i = 0; i < 10; i++)
			send(make_assign(i * 4, i * 4 + 2, 8'(i + 1)));
		send(make_lookup(5));
		send(make_lookup(-1));

		// default changed with breakpoints in place
		write_default(8'hff);
		send(make_lookup(-1000));
		send(make_assign(-2000, 1000, 8'hff));

		// long receiver hold-off while requests keep coming
		hold_off = 1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			begin
				for (int i = 0; i < 12; i++)
					send(make_lookup($urandom));
				push <= 0;
			end
		join
		@(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			if (ph > 0)
				write_default(ph == 3 ? 8'h00 : 8'($urandom));
			foreach (pool[i])
				pool[i] = (ph == 2) ? $urandom : $signed($urandom_range(0, 60)) - 30;
			for (int n = 0; n < 270; n++) begin
				if ($urandom_range(0, 1)) begin
					send(make_lookup(pick_key()));
				end else begin
					a = pick_key();
					b = pick_key();
					if ($urandom_range(0, 9) != 0 && a > b) begin
						r.range_begin = a; a = b; b = r.range_begin;
					end
					send(make_assign(a, b, $urandom_range(0, 3) == 0 ? 8'($urandom)
						: 8'($urandom_range(0, 3))));
				end
			end
		end
		push <= 0;

		wait (sb.pending.size() == 0);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

@@ interval_map_range_table_core.f @@
hdl/imrt_pkg.sv
hdl/imrt_front.sv
hdl/imrt_engine.sv
hdl/interval_map_range_table_core.sv
tb/tb.sv
